// ===== src/ffba_pkg.sv =====
// Shared types and constants for the first-fit bin allocator.
// Used by ffba_cell and first_fit_bin_allocator_core; no dependencies.
package ffba_pkg;

    localparam int unsigned SIZE_W = 16;
    localparam int unsigned INDEX_OUT_W = 8;
    localparam int unsigned USED_OUT_W = 9;

    localparam logic [SIZE_W-1:0] CAP_RESET = 16'd32801;

    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } ffba_state_t;

    // Request moving along the row of bin cells.
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] fill;
    } ffba_token_t;

endpackage

// ===== src/ffba_cell.sv =====
// One bin of the allocator row: holds the bin fill and passes the request on.
// Depends on ffba_pkg.
module ffba_cell
    import ffba_pkg::*;
#(
    parameter int unsigned IDX_W    = 8,
    parameter int unsigned CELL_IDX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic [SIZE_W-1:0] capacity,
    input  ffba_token_t       tok_in,
    input  logic [IDX_W-1:0]  idx_in,
    output ffba_token_t       tok_out,
    output logic [IDX_W-1:0]  idx_out
);

    logic [SIZE_W-1:0] fill_reg;
    logic [SIZE_W-1:0] fill_next;
    ffba_token_t       tok_reg;
    ffba_token_t       tok_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [SIZE_W:0]   sum;
    logic              take;

    assign sum  = {1'b0, fill_reg} + {1'b0, tok_in.size};
    assign take = tok_in.valid && !tok_in.found && (sum <= {1'b0, capacity});

    always_comb
    begin
        fill_next = fill_reg;
        tok_next  = tok_in;
        idx_next  = idx_in;
        if (clear)
        begin
            fill_next = '0;
        end
        else if (take)
        begin
            fill_next     = sum[SIZE_W-1:0];
            tok_next.found = 1'b1;
            tok_next.fill  = sum[SIZE_W-1:0];
            idx_next       = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            tok_reg  <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            tok_reg  <= tok_next;
            idx_reg  <= idx_next;
        end
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

// ===== src/first_fit_bin_allocator_core.sv =====
// Top level of the first-fit bin allocator: request control, row of bin cells,
// result and output registers. Depends on ffba_pkg and ffba_cell.
//
// Usage:
//   Input channel (in_valid / in_stall) carries cmd and item_size. A place
//   request walks the row of NUM_BINS bin cells, one cell per cycle; the
//   first cell whose fill plus the size stays within bin_capacity takes it.
//   A clear request empties every bin at once.
//   Output channel (out_valid / out_stall) returns one result per request.
//   A place request's result passes from the last cell into a holding
//   register and then into the output register; a clear request's result
//   is loaded straight into the holding register. The block works on one
//   request at a time and takes no new request until the previous result
//   has moved to the output register. The next request is accepted while
//   the previous result still sits in the output register.
//   When the receiver stalls, the finished result waits in a holding
//   register and in_stall stays high until it moves to the output register.
//   Reset empties all bins, zeroes the used-bin count and loads
//   bin_capacity with 32801 (1.001 in Q1.15). cfg_we writes bin_capacity.
module first_fit_bin_allocator_core
    import ffba_pkg::*;
#(
    parameter int unsigned NUM_BINS = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [SIZE_W-1:0]      cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   cmd,
    input  logic [SIZE_W-1:0]      item_size,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [INDEX_OUT_W-1:0] bin_index,
    output logic [SIZE_W-1:0]      bin_fill_after,
    output logic [USED_OUT_W-1:0]  bins_used,
    output logic                   no_fit
);

    localparam int unsigned IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int unsigned HU_W  = $clog2(NUM_BINS + 1);

    ffba_state_t state_reg;
    ffba_state_t state_next;

    logic [SIZE_W-1:0] cap_reg;
    logic [HU_W-1:0]   hu_reg;
    logic [HU_W-1:0]   hu_next;
    logic [HU_W-1:0]   hu_cand;

    logic                   res_nofit_reg;
    logic [INDEX_OUT_W-1:0] res_index_reg;
    logic [SIZE_W-1:0]      res_fill_reg;
    logic [USED_OUT_W-1:0]  res_used_reg;

    logic                   out_valid_reg;
    logic                   out_nofit_reg;
    logic [INDEX_OUT_W-1:0] out_index_reg;
    logic [SIZE_W-1:0]      out_fill_reg;
    logic [USED_OUT_W-1:0]  out_used_reg;

    logic                   in_accept;
    logic                   clear_req;
    logic                   out_load;
    logic                   end_valid;
    logic [INDEX_OUT_W-1:0] end_index_w;
    logic [USED_OUT_W-1:0]  hu_next_w;

    ffba_token_t      tok [0:NUM_BINS];
    logic [IDX_W-1:0] idx [0:NUM_BINS];

    assign in_accept = in_valid && !in_stall;
    assign clear_req = in_accept && (cmd == CMD_CLEAR);
    assign end_valid = tok[NUM_BINS].valid;

    // Launch a place request into the first cell.
    assign tok[0] = {in_accept && (cmd == CMD_PLACE), 1'b0, item_size, {SIZE_W{1'b0}}};
    assign idx[0] = '0;

    for (genvar g = 0; g < NUM_BINS; g++)
    begin : g_cell
        ffba_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (clear_req),
            .capacity (cap_reg),
            .tok_in   (tok[g]),
            .idx_in   (idx[g]),
            .tok_out  (tok[g+1]),
            .idx_out  (idx[g+1])
        );
    end

    if (IDX_W >= INDEX_OUT_W)
    begin : g_idx_trunc
        assign end_index_w = idx[NUM_BINS][INDEX_OUT_W-1:0];
    end
    else
    begin : g_idx_ext
        assign end_index_w = {{(INDEX_OUT_W-IDX_W){1'b0}}, idx[NUM_BINS]};
    end

    if (HU_W >= USED_OUT_W)
    begin : g_hu_trunc
        assign hu_next_w = hu_next[USED_OUT_W-1:0];
    end
    else
    begin : g_hu_ext
        assign hu_next_w = {{(USED_OUT_W-HU_W){1'b0}}, hu_next};
    end

    assign hu_cand = HU_W'(idx[NUM_BINS]) + HU_W'(1);

    always_comb
    begin
        hu_next = hu_reg;
        if (clear_req)
        begin
            hu_next = '0;
        end
        else if (end_valid && tok[NUM_BINS].found && (hu_cand > hu_reg))
        begin
            hu_next = hu_cand;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (cmd == CMD_CLEAR) ? ST_HOLD : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (end_valid)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State-derived control outputs.
    always_comb
    begin
        in_stall = 1'b1;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_RUN:
            begin
                in_stall = 1'b1;
            end
            ST_HOLD:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            hu_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hu_reg    <= hu_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result holding and output payload registers.
    always_ff @(posedge clk)
    begin
        if (clear_req)
        begin
            res_nofit_reg <= 1'b0;
            res_index_reg <= '0;
            res_fill_reg  <= '0;
            res_used_reg  <= '0;
        end
        else if (end_valid)
        begin
            res_nofit_reg <= !tok[NUM_BINS].found;
            res_index_reg <= tok[NUM_BINS].found ? end_index_w : '0;
            res_fill_reg  <= tok[NUM_BINS].found ? tok[NUM_BINS].fill : '0;
            res_used_reg  <= hu_next_w;
        end
        if (out_load)
        begin
            out_nofit_reg <= res_nofit_reg;
            out_index_reg <= res_index_reg;
            out_fill_reg  <= res_fill_reg;
            out_used_reg  <= res_used_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign no_fit         = out_nofit_reg;
    assign bin_index      = out_index_reg;
    assign bin_fill_after = out_fill_reg;
    assign bins_used      = out_used_reg;

endmodule

// ===== src/ffba_checker.sv =====
// Port-level checks for the first-fit bin allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_bin_allocator_core.
module ffba_checker
    import ffba_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [INDEX_OUT_W-1:0] bin_index,
    input logic [SIZE_W-1:0]      bin_fill_after,
    input logic                   no_fit
);

    // A result held by the receiver stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // The block takes one request at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while another is in flight");

    // A request that found no bin reports bin zero with zero fill.
    a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_fit |-> (bin_index == '0) && (bin_fill_after == '0))
        else $error("no-fit result carries a bin");

endmodule

bind first_fit_bin_allocator_core ffba_checker u_ffba_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .bin_index      (bin_index),
    .bin_fill_after (bin_fill_after),
    .no_fit         (no_fit)
);

// ===== dv/first_fit_bin_allocator_core_test.sv =====
// Self-checking testbench for first_fit_bin_allocator_core: directed table, then random phases.
// Expected results: typed rows or a first-fit predictor. Depends on ffba_pkg and the core RTL.
`timescale 1ns / 1ps

module first_fit_bin_allocator_core_test;
    import ffba_pkg::*;

    localparam int unsigned NUM_BINS = 256;
    localparam int PLAN_LEN = 23;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [INDEX_OUT_W-1:0] bin;
        logic [SIZE_W-1:0]      fill;
        logic [USED_OUT_W-1:0]  used;
        logic                   nofit;
    } placement_t;

    typedef struct packed {
        logic              is_cfg;
        logic              cmd;
        logic [SIZE_W-1:0] size;
        logic              typed;
        placement_t        want;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [SIZE_W-1:0]      cfg_wdata;
    logic                   in_valid;
    logic                   in_stall;
    logic                   cmd;
    logic [SIZE_W-1:0]      item_size;
    logic                   out_valid;
    logic                   out_stall;
    logic [INDEX_OUT_W-1:0] bin_index;
    logic [SIZE_W-1:0]      bin_fill_after;
    logic [USED_OUT_W-1:0]  bins_used;
    logic                   no_fit;

    // Predictor state: bin fills, used-bin count and the capacity register.
    logic [SIZE_W-1:0] fill_model [NUM_BINS];
    int unsigned       used_model;
    logic [SIZE_W-1:0] cap_model;

    placement_t pending_results[$];
    plan_row_t  plan [PLAN_LEN];
    int         mismatches;
    int         gap_pct;
    int         stall_pct;
    int         cycle_count;

    first_fit_bin_allocator_core #(
        .NUM_BINS(NUM_BINS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .item_size(item_size),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .bin_index(bin_index),
        .bin_fill_after(bin_fill_after),
        .bins_used(bins_used),
        .no_fit(no_fit)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic placement_t predict_placement(logic c, logic [SIZE_W-1:0] sz);
        placement_t r;
        logic [SIZE_W:0] sum;
        bit placed;
        r = '0;
        placed = 0;
        if (c == CMD_CLEAR)
        begin
            for (int b = 0; b < NUM_BINS; b++)
                fill_model[b] = '0;
            used_model = 0;
            return r;
        end
        for (int b = 0; b < NUM_BINS && !placed; b++)
        begin
            sum = {1'b0, fill_model[b]} + {1'b0, sz};
            if (sum <= {1'b0, cap_model})
            begin
                fill_model[b] = sum[SIZE_W-1:0];
                if (used_model < b + 1)
                    used_model = b + 1;
                r.bin = INDEX_OUT_W'(b);
                r.fill = sum[SIZE_W-1:0];
                placed = 1;
            end
        end
        r.used = USED_OUT_W'(used_model);
        r.nofit = !placed;
        return r;
    endfunction

    function automatic plan_row_t req_row(logic c, logic [SIZE_W-1:0] sz, logic typed,
                                          logic [INDEX_OUT_W-1:0] b, logic [SIZE_W-1:0] f,
                                          logic [USED_OUT_W-1:0] u, logic nf);
        plan_row_t r;
        r.is_cfg = 1'b0;
        r.cmd = c;
        r.size = sz;
        r.typed = typed;
        r.want.bin = b;
        r.want.fill = f;
        r.want.used = u;
        r.want.nofit = nf;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(logic [SIZE_W-1:0] v);
        plan_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.size = v;
        return r;
    endfunction

    task automatic set_idling(input int m);
        case (m)
            0:
            begin
                gap_pct = 31;
                stall_pct = 67;
            end
            1:
            begin
                gap_pct = 67;
                stall_pct = 31;
            end
            default:
            begin
                gap_pct = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    // Drives one request and records its expected result once it is accepted.
    task automatic send_request(input logic c, input logic [SIZE_W-1:0] sz, input logic typed,
                                input placement_t want);
        placement_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        cmd = c;
        item_size = sz;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_placement(c, sz);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [SIZE_W-1:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        cap_model = v;
    endtask

    task automatic run_phase(input int m, input logic [SIZE_W-1:0] cap, input int count,
                             input int lo, input int clear_pct, input bit start_clear);
        int pick;
        drain();
        write_capacity(cap);
        set_idling(m);
        if (start_clear)
            send_request(CMD_CLEAR, SIZE_W'($urandom_range(65535)), 1'b0, '0);
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < clear_pct)
                send_request(CMD_CLEAR, SIZE_W'($urandom_range(65535)), 1'b0, '0);
            else if (pick < clear_pct + 10)
                send_request(CMD_PLACE, SIZE_W'($urandom_range(65535)), 1'b0, '0);
            else
                send_request(CMD_PLACE, SIZE_W'($urandom_range(lo, cap)), 1'b0, '0);
        end
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        placement_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: bin %0d fill %0d used %0d no_fit %0d",
                             bin_index, bin_fill_after, bins_used, no_fit);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (bin_index !== want.bin || bin_fill_after !== want.fill ||
                    bins_used !== want.used || no_fit !== want.nofit)
                begin
                    if (mismatches < 10)
                        $display({"result mismatch: expected bin %0d fill %0d used %0d ",
                                  "no_fit %0d, got bin %0d fill %0d used %0d no_fit %0d"},
                                 want.bin, want.fill, want.used, want.nofit,
                                 bin_index, bin_fill_after, bins_used, no_fit);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** first_fit_bin_allocator_core: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        cmd = CMD_PLACE;
        item_size = '0;
        mismatches = 0;
        set_idling(0);
        for (int b = 0; b < NUM_BINS; b++)
            fill_model[b] = '0;
        used_model = 0;
        cap_model = CAP_RESET;

        // Reset capacity first: zero size, exact fit, oversize items and a clear.
        plan[0]  = req_row(CMD_PLACE, 16'd0,     1'b1, 8'd0, 16'd0,     9'd1, 1'b0);
        plan[1]  = req_row(CMD_PLACE, 16'd32768, 1'b1, 8'd0, 16'd32768, 9'd1, 1'b0);
        plan[2]  = req_row(CMD_PLACE, 16'd33,    1'b1, 8'd0, 16'd32801, 9'd1, 1'b0);
        plan[3]  = req_row(CMD_PLACE, 16'd1,     1'b1, 8'd1, 16'd1,     9'd2, 1'b0);
        plan[4]  = req_row(CMD_PLACE, 16'd32800, 1'b1, 8'd1, 16'd32801, 9'd2, 1'b0);
        plan[5]  = req_row(CMD_PLACE, 16'd65535, 1'b1, 8'd0, 16'd0,     9'd2, 1'b1);
        plan[6]  = req_row(CMD_PLACE, 16'd32802, 1'b1, 8'd0, 16'd0,     9'd2, 1'b1);
        plan[7]  = req_row(CMD_PLACE, 16'd32801, 1'b1, 8'd2, 16'd32801, 9'd3, 1'b0);
        plan[8]  = req_row(CMD_CLEAR, 16'd65535, 1'b1, 8'd0, 16'd0,     9'd0, 1'b0);
        plan[9]  = req_row(CMD_PLACE, 16'd0,     1'b1, 8'd0, 16'd0,     9'd1, 1'b0);
        plan[10] = cfg_row(16'd0);
        plan[11] = req_row(CMD_PLACE, 16'd0,     1'b1, 8'd0, 16'd0,     9'd1, 1'b0);
        plan[12] = req_row(CMD_PLACE, 16'd1,     1'b1, 8'd0, 16'd0,     9'd1, 1'b1);
        plan[13] = cfg_row(16'd65535);
        plan[14] = req_row(CMD_PLACE, 16'd65535, 1'b1, 8'd0, 16'd65535, 9'd1, 1'b0);
        plan[15] = req_row(CMD_PLACE, 16'd1,     1'b1, 8'd1, 16'd1,     9'd2, 1'b0);
        // Capacity now drops below the fill of bin 0, which must be skipped.
        plan[16] = cfg_row(16'd100);
        plan[17] = req_row(CMD_PLACE, 16'd50,    1'b0, '0, '0, '0, 1'b0);
        plan[18] = req_row(CMD_PLACE, 16'd60,    1'b0, '0, '0, '0, 1'b0);
        plan[19] = req_row(CMD_PLACE, 16'd0,     1'b0, '0, '0, '0, 1'b0);
        plan[20] = req_row(CMD_PLACE, 16'd40,    1'b0, '0, '0, '0, 1'b0);
        plan[21] = req_row(CMD_CLEAR, 16'd0,     1'b1, 8'd0, 16'd0,     9'd0, 1'b0);
        plan[22] = req_row(CMD_PLACE, 16'd32768, 1'b1, 8'd0, 16'd0,     9'd0, 1'b1);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int k = 0; k < PLAN_LEN; k++)
        begin
            if (plan[k].is_cfg)
            begin
                drain();
                write_capacity(plan[k].size);
            end
            else
            begin
                send_request(plan[k].cmd, plan[k].size, plan[k].typed, plan[k].want);
            end
        end

        // With a tiny capacity (second phase) most items open a new bin, so the whole row fills up.
        run_phase(0, 16'd32768, 150, 0, 3, 1'b0);
        run_phase(1, 16'd7,     330, 4, 0, 1'b1);
        run_phase(1, 16'd65535, 80,  0, 5, 1'b0);
        run_phase(2, 16'd0,     40,  0, 5, 1'b0);
        run_phase(2, SIZE_W'($urandom_range(65535)), 100, 0, 5, 1'b0);

        drain();
        repeat (NUM_BINS + 8) @(negedge clk);
        if (mismatches == 0)
            $display("** first_fit_bin_allocator_core: PASSED **");
        else
            $display("** first_fit_bin_allocator_core: FAILED **");
        $finish;
    end

endmodule
